// File: src/ebm_pkg.sv
package ebm_pkg;

  localparam int CfgW      = 11;
  localparam int CfgIdxW   = 1;
  localparam int PixW      = 8;
  localparam int PixIdxW   = 20;

  localparam logic [CfgIdxW-1:0] CfgImageWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgImageHeight = 1'b1;

  localparam logic [CfgW-1:0] CfgWidthReset  = 11'd1024;
  localparam logic [CfgW-1:0] CfgHeightReset = 11'd1024;

  localparam logic CmdPixel = 1'b0;
  localparam logic CmdFlush = 1'b1;

  typedef struct packed {
    logic            command;
    logic [PixW-1:0] pixel_value;
  } in_word_t;

  typedef struct packed {
    logic [PixIdxW-1:0] pixel_index;
    logic               is_border;
    logic               last_of_frame;
  } out_word_t;

endpackage

// File: src/ebm_cell.sv
module ebm_cell (
  input  logic clk_i,
  input  logic shift_i,
  input  logic insert_i,
  input  logic ins_flag_i,
  input  logic next_flag_i,
  output logic flag_o
);

  logic flag_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      flag_q <= insert_i ? ins_flag_i : next_flag_i;
    end
  end

  assign flag_o = flag_q;

endmodule

// File: src/ebm_line.sv
module ebm_line #(
  parameter int Depth = 1024,
  parameter int IdxW  = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic            clk_i,
  input  logic            shift_i,
  input  logic [IdxW-1:0] last_i,
  input  logic            flag_i,
  output logic            head_o,
  output logic            next_o
);

  // cell i takes the new flag when it is the tail of the active row length,
  // else the flag of cell i+1; cell 0 therefore delays by last_i+1 words
  logic [Depth:0] chain;

  assign chain[Depth] = 1'b0;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    ebm_cell u_cell (
      .clk_i      (clk_i),
      .shift_i    (shift_i),
      .insert_i   (last_i == IdxW'(i)),
      .ins_flag_i (flag_i),
      .next_flag_i(chain[i+1]),
      .flag_o     (chain[i])
    );
  end

  assign head_o = chain[0];
  assign next_o = chain[1];

endmodule

// File: src/ebm_skid.sv
module ebm_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ebm_pkg::out_word_t push_word_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ebm_pkg::out_word_t out_word_o
);

  import ebm_pkg::*;

  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_word_t out_word_q, out_word_d;
  out_word_t skid_word_q, skid_word_d;
  logic      out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_word_d   = out_word_q;
    skid_word_d  = skid_word_q;
    if (out_free) begin
      if (skid_valid_q) begin
        // drain the skid word first to keep order
        out_word_d   = skid_word_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_word_d  = push_word_i;
        out_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_word_d  = push_word_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q  <= out_word_d;
    skid_word_q <= skid_word_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// File: src/external_border_marker.sv
// A pixel's word is built when the pixel below it (or a last-row flush word) is
// accepted and goes to the output or skid register. Throughput: one input word
// per cycle while in_stall_o is low; two row stores are chains of flag cells
// shifted once per counted pixel or flush word; no memory port limits the rate.
// Reset: counters cleared, image size 1024 x 1024, row stores not cleared.
module external_border_marker #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ebm_pkg::in_word_t             in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ebm_pkg::out_word_t            out_word_o,
  input  logic                          cfg_we_i,
  input  logic [ebm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ebm_pkg::CfgW-1:0]      cfg_data_i
);

  import ebm_pkg::*;

  localparam int ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RowW = $clog2(MAX_HEIGHT + 1);

  function automatic logic [ColW-1:0] clamp_wlast(input logic [CfgW-1:0] v);
    logic [ColW-1:0] r;
    if (32'(v) > MAX_WIDTH) begin
      r = ColW'(MAX_WIDTH - 1);
    end else if (v == '0) begin
      r = '0;
    end else begin
      r = ColW'(v - 1'b1);
    end
    return r;
  endfunction

  function automatic logic [RowW-1:0] clamp_h(input logic [CfgW-1:0] v);
    logic [RowW-1:0] r;
    if (32'(v) > MAX_HEIGHT) begin
      r = RowW'(MAX_HEIGHT);
    end else if (v == '0) begin
      r = RowW'(1);
    end else begin
      r = RowW'(v);
    end
    return r;
  endfunction

  logic [ColW-1:0]    wlast_q, wlast_d;
  logic [RowW-1:0]    h_q, h_d;
  logic [ColW-1:0]    col_q, col_d;
  logic [RowW-1:0]    row_q, row_d;
  logic [PixIdxW-1:0] pos_q, pos_d;
  logic               left_q, left_d;

  logic      accept, flush, cur, rows_done, pix_go, flush_go, shift;
  logic      col_last, mid_c, mid_n, up_c;
  logic      obj_near, emit, full;
  out_word_t res_word;

  assign accept    = in_valid_i && !in_stall_o;
  assign flush     = (in_word_i.command == CmdFlush);
  assign cur       = |in_word_i.pixel_value;
  assign rows_done = (row_q >= h_q);
  assign pix_go    = accept && !flush && !rows_done;
  assign flush_go  = accept && flush && rows_done;
  assign shift     = pix_go || flush_go;
  assign col_last  = (col_q == wlast_q);

  ebm_line #(.Depth(MAX_WIDTH), .IdxW(ColW)) u_mid (
    .clk_i  (clk_i),
    .shift_i(shift),
    .last_i (wlast_q),
    .flag_i (cur),
    .head_o (mid_c),
    .next_o (mid_n)
  );

  ebm_line #(.Depth(MAX_WIDTH), .IdxW(ColW)) u_up (
    .clk_i  (clk_i),
    .shift_i(shift),
    .last_i (wlast_q),
    .flag_i (mid_c),
    .head_o (up_c),
    .next_o ()
  );

  // during a flush the row count equals the height, so one test covers both
  always_comb begin
    obj_near = (pix_go && cur)
            || ((row_q >= RowW'(2)) && up_c)
            || ((col_q != '0) && left_q)
            || (!col_last && mid_n);
  end

  assign emit = (pix_go && (row_q != '0)) || flush_go;

  always_comb begin
    res_word.pixel_index   = pos_q;
    res_word.is_border     = !mid_c && obj_near;
    res_word.last_of_frame = flush_go && col_last;
  end

  always_comb begin
    wlast_d = wlast_q;
    h_d     = h_q;
    col_d   = col_q;
    row_d   = row_q;
    pos_d   = pos_q;
    left_d  = left_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CfgImageWidth:  wlast_d = clamp_wlast(cfg_data_i);
        CfgImageHeight: h_d     = clamp_h(cfg_data_i);
        default: ;
      endcase
      // restart the frame on any register write
      col_d  = '0;
      row_d  = '0;
      pos_d  = '0;
      left_d = 1'b0;
    end else if (pix_go) begin
      if (emit) begin
        pos_d = pos_q + 1'b1;
      end
      if (col_last) begin
        col_d  = '0;
        row_d  = row_q + 1'b1;
        left_d = 1'b0;
      end else begin
        col_d  = col_q + 1'b1;
        left_d = mid_c;
      end
    end else if (flush_go) begin
      if (col_last) begin
        col_d  = '0;
        row_d  = '0;
        pos_d  = '0;
        left_d = 1'b0;
      end else begin
        col_d  = col_q + 1'b1;
        pos_d  = pos_q + 1'b1;
        left_d = mid_c;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlast_q <= clamp_wlast(CfgWidthReset);
      h_q     <= clamp_h(CfgHeightReset);
      col_q   <= '0;
      row_q   <= '0;
      pos_q   <= '0;
      left_q  <= 1'b0;
    end else begin
      wlast_q <= wlast_d;
      h_q     <= h_d;
      col_q   <= col_d;
      row_q   <= row_d;
      pos_q   <= pos_d;
      left_q  <= left_d;
    end
  end

  ebm_skid u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (emit),
    .push_word_i(res_word),
    .full_o     (full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  assign in_stall_o = full;

endmodule

// File: dv/border_marker_checker.sv
module border_marker_checker #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  ebm_pkg::in_word_t           in_word_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  ebm_pkg::out_word_t          out_word_i,
  input  logic                        cfg_we_i,
  input  logic [ebm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [ebm_pkg::CfgW-1:0]    cfg_data_i,
  output int                          mismatches_o,
  output int                          outstanding_o,
  output int                          decisions_o,
  output int                          borders_o
);

  bit                     upper_flags [MAX_WIDTH];
  bit                     middle_flags [MAX_WIDTH];
  int                     in_col;
  int                     in_row;
  int unsigned            out_pos;
  bit                     left_flag;
  logic [ebm_pkg::CfgW-1:0] width_reg;
  logic [ebm_pkg::CfgW-1:0] height_reg;
  ebm_pkg::out_word_t     border_decisions_q[$];

  function automatic int clamp_dim(int v, int maxv);
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Decision for the middle-row pixel at column c.
  function automatic bit border_at(int c, int w, bit has_up, bit below);
    if (middle_flags[c]) return 1'b0;
    return below || (has_up && upper_flags[c]) || (c >= 1 && left_flag) ||
           (c + 1 < w && middle_flags[c + 1]);
  endfunction

  task automatic restart_frame();
    in_col    = 0;
    in_row    = 0;
    out_pos   = 0;
    left_flag = 1'b0;
  endtask

  task automatic take_word(ebm_pkg::in_word_t word);
    int                 w;
    int                 h;
    int                 c;
    bit                 obj;
    ebm_pkg::out_word_t dec;
    w   = clamp_dim(int'(width_reg), MAX_WIDTH);
    h   = clamp_dim(int'(height_reg), MAX_HEIGHT);
    c   = (in_col >= w) ? 0 : in_col;
    obj = (word.pixel_value != '0);
    if (word.command == ebm_pkg::CmdPixel) begin
      // drop pixels once the frame is complete
      if (in_row >= h) return;
      if (in_row >= 1) begin
        dec.pixel_index   = out_pos[ebm_pkg::PixIdxW-1:0];
        dec.is_border     = border_at(c, w, in_row >= 2, obj);
        dec.last_of_frame = 1'b0;
        border_decisions_q.push_back(dec);
        out_pos++;
      end
      upper_flags[c]  = middle_flags[c];
      left_flag       = middle_flags[c];
      middle_flags[c] = obj;
      if (c + 1 >= w) begin
        in_col    = 0;
        in_row++;
        left_flag = 1'b0;
      end else begin
        in_col = c + 1;
      end
    end else begin
      // a flush before the last row is complete is ignored
      if (in_row < h) return;
      dec.pixel_index   = out_pos[ebm_pkg::PixIdxW-1:0];
      dec.is_border     = border_at(c, w, h >= 2, 1'b0);
      dec.last_of_frame = (c + 1 >= w);
      border_decisions_q.push_back(dec);
      left_flag = middle_flags[c];
      if (c + 1 >= w) begin
        restart_frame();
      end else begin
        in_col = c + 1;
        out_pos++;
      end
    end
  endtask

  task automatic check_decision(ebm_pkg::out_word_t got);
    ebm_pkg::out_word_t want;
    if (border_decisions_q.size() == 0) begin
      mismatches_o++;
      if (mismatches_o <= 10)
        $display("unexpected decision word: index %0d border %0b last %0b",
                 got.pixel_index, got.is_border, got.last_of_frame);
      return;
    end
    want = border_decisions_q.pop_front();
    decisions_o++;
    if (got.is_border) borders_o++;
    if (got.pixel_index !== want.pixel_index || got.is_border !== want.is_border ||
        got.last_of_frame !== want.last_of_frame) begin
      mismatches_o++;
      if (mismatches_o <= 10)
        $display("mismatch: want %0d/%0b/%0b got %0d/%0b/%0b (index/border/last)",
                 want.pixel_index, want.is_border, want.last_of_frame,
                 got.pixel_index, got.is_border, got.last_of_frame);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg     = ebm_pkg::CfgWidthReset;
      height_reg    = ebm_pkg::CfgHeightReset;
      restart_frame();
      mismatches_o  = 0;
      outstanding_o = 0;
      decisions_o   = 0;
      borders_o     = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_decision(out_word_i);
      if (cfg_we_i) begin
        if (cfg_index_i == ebm_pkg::CfgImageWidth) width_reg = cfg_data_i;
        else height_reg = cfg_data_i;
        restart_frame();
      end
      if (in_valid_i && !in_stall_i) take_word(in_word_i);
      outstanding_o = border_decisions_q.size();
    end
  end

endmodule

// File: dv/external_border_marker_test.sv
module external_border_marker_test;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_stall_o;
  ebm_pkg::in_word_t           in_word_i   = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  ebm_pkg::out_word_t          out_word_o;
  logic                        cfg_we_i    = 1'b0;
  logic [ebm_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [ebm_pkg::CfgW-1:0]    cfg_data_i  = '0;

  int mismatches;
  int outstanding;
  int decisions;
  int borders;

  bit calm          = 1'b0;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int frames        = 0;
  int words_sent    = 0;
  int ignored_words = 0;
  int good_words    = 0;

  always #2 clk_i = ~clk_i;

  external_border_marker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  border_marker_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .in_word_i     (in_word_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_word_i    (out_word_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .decisions_o   (decisions),
    .borders_o     (borders)
  );

  // Result side: random stalls, or a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left    <= 300;
      out_stall_i  <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 29);
    end
  end

  function automatic logic [7:0] pick_pixel(int obj_pct);
    if ($urandom_range(99) < obj_pct) return 8'($urandom_range(1, 255));
    return 8'd0;
  endfunction

  task automatic send_word(logic cmd, logic [7:0] value);
    ebm_pkg::in_word_t next_word;
    next_word.command     = cmd;
    next_word.pixel_value = value;
    while (!calm && $urandom_range(99) < 29) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= next_word;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  // Drain every pending decision, then let the pipeline go quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (outstanding == 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_size(int width_val, int height_val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= ebm_pkg::CfgImageWidth;
    cfg_data_i  <= width_val[ebm_pkg::CfgW-1:0];
    @(posedge clk_i);
    cfg_index_i <= ebm_pkg::CfgImageHeight;
    cfg_data_i  <= height_val[ebm_pkg::CfgW-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Send cut pixels of a w x h frame; a whole frame also gets its flush row.
  task automatic run_frame(int w, int h, int obj_pct, bit noisy, int cut);
    for (int p = 0; p < cut; p++) begin
      if (noisy && $urandom_range(9) == 0) begin
        send_word(ebm_pkg::CmdFlush, 8'($urandom_range(255)));
        ignored_words++;
      end
      send_word(ebm_pkg::CmdPixel, pick_pixel(obj_pct));
      good_words++;
    end
    if (cut == w * h) begin
      for (int c = 0; c < w; c++) begin
        if (noisy && $urandom_range(4) == 0) begin
          send_word(ebm_pkg::CmdPixel, 8'($urandom_range(255)));
          ignored_words++;
        end
        send_word(ebm_pkg::CmdFlush, 8'($urandom_range(255)));
        good_words++;
      end
      frames++;
    end
  endtask

  initial begin
    int w;
    int h;
    int cut;
    int kind;
    int rounds;
    bit keep;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 3 x 3 frame with a stray flush mid-frame and a stray pixel while draining
    set_size(3, 3);
    send_word(ebm_pkg::CmdPixel, 8'h00);
    send_word(ebm_pkg::CmdPixel, 8'hff);
    send_word(ebm_pkg::CmdPixel, 8'h00);
    send_word(ebm_pkg::CmdFlush, 8'h55);
    send_word(ebm_pkg::CmdPixel, 8'h01);
    send_word(ebm_pkg::CmdPixel, 8'h00);
    send_word(ebm_pkg::CmdPixel, 8'h80);
    send_word(ebm_pkg::CmdPixel, 8'h00);
    send_word(ebm_pkg::CmdPixel, 8'h00);
    send_word(ebm_pkg::CmdPixel, 8'haa);
    send_word(ebm_pkg::CmdPixel, 8'hff);
    for (int c = 0; c < 3; c++) send_word(ebm_pkg::CmdFlush, 8'h00);
    frames++;

    // zero sizes act as 1 x 1; two frames back to back
    settle();
    set_size(0, 0);
    send_word(ebm_pkg::CmdPixel, 8'h00);
    send_word(ebm_pkg::CmdFlush, 8'h00);
    send_word(ebm_pkg::CmdPixel, 8'hff);
    send_word(ebm_pkg::CmdFlush, 8'hff);
    settle();
    set_size(1, 2);
    send_word(ebm_pkg::CmdPixel, 8'h00);
    send_word(ebm_pkg::CmdPixel, 8'hc8);
    send_word(ebm_pkg::CmdFlush, 8'h00);
    frames += 3;

    // a whole frame with no idling on either side
    settle();
    set_size(16, 8);
    calm = 1'b1;
    run_frame(16, 8, 50, 1'b0, 16 * 8);
    calm = 1'b0;

    // oversized values clamp to the maximum; cut frames keep the run short
    settle();
    set_size(0, 2047);
    run_frame(1, 1024, 30, 1'b0, 48);
    settle();
    set_size(2047, 2);
    run_frame(1024, 2, 50, 1'b1, 40);

    rounds  = 0;
    keep    = 1'b0;
    w       = 1;
    h       = 1;
    while (words_sent < 650 || rounds <= 3) begin
      if (!keep || rounds == 3) begin
        w = ($urandom_range(5) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
        h = $urandom_range(1, 6);
        if (rounds == 3) begin
          w = 40;
          h = 5;
        end
        settle();
        set_size(w, h);
        // stall the result side long enough to back the block up
        if (rounds == 3) hold_requests++;
      end
      kind = $urandom_range(9);
      cut  = (kind == 9 && rounds != 3) ? $urandom_range(0, w * h - 1) : w * h;
      run_frame(w, h, $urandom_range(5, 95), kind == 8, cut);
      keep = (cut == w * h) && ($urandom_range(3) == 0);
      rounds++;
    end

    settle();
    $display("ran %0d frames, %0d input words (%0d deliberately ignored)",
             frames, words_sent, ignored_words);
    $display("checked %0d decisions, %0d border pixels; zero and oversized sizes clamped",
             decisions, borders);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
